@@ rtl/irpds_pkg.sv @@
`timescale 1ns / 1ps

package irpds_pkg;

  localparam int MAX_BYTES_DEF = 32;

  localparam int DUR_W  = 20;
  localparam int SHORT_W = 16;
  localparam int CFG_W  = 20;
  localparam int CFG_IDX_W = 3;

  localparam logic [SHORT_W-1:0] LEADER_MARK_RST  = 16'd9000;
  localparam logic [SHORT_W-1:0] LEADER_SPACE_RST = 16'd4500;
  localparam logic [SHORT_W-1:0] BIT_MARK_RST     = 16'd560;
  localparam logic [SHORT_W-1:0] ONE_SPACE_RST    = 16'd1690;
  localparam logic [SHORT_W-1:0] ZERO_SPACE_RST   = 16'd560;
  localparam logic [DUR_W-1:0]   FRAME_GAP_RST    = 20'd40000;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_LOAD_ONE = 2'd1,
    KIND_LOAD_TWO = 2'd2,
    KIND_START    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_FRAME_GAP    = 3'd5,
    REG_SECOND_EN    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_TRAIL_MARK = 3'd5,
    PH_GAP        = 3'd6
  } phase_t;

  typedef struct packed {
    logic ir_gate;
    logic busy;
    logic done;
    logic rejected;
  } result_t;

  // A zero duration still lasts one tick.
  function automatic logic [DUR_W-1:0] dur_fix(input logic [DUR_W-1:0] d);
    return (d == '0) ? DUR_W'(1) : d;
  endfunction

endpackage

@@ rtl/irpds_ram.sv @@
`timescale 1ns / 1ps

module irpds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = irpds_pkg::MAX_BYTES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ir_pulse_distance_sender_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   kind, data_byte
// out       out_valid / out_ready ir_gate, busy_res, done_res, rejected
// cfg       cfg_we                cfg_index, cfg_data
//
// One request per clock while in_ready is high; its result is registered in the output buffer.
// A two-entry output buffer keeps input accepted while one result waits.
// in_ready drops only when both buffer entries are full.
// Frame bytes live in two registered-read RAMs; the next byte is fetched
// during the phase before it is needed. rst is synchronous and clears control.

module ir_pulse_distance_sender_unit #(
  parameter int MAX_BYTES = irpds_pkg::MAX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ir_gate,
  output logic                           busy_res,
  output logic                           done_res,
  output logic                           rejected,
  input  logic                           cfg_we,
  input  logic [irpds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpds_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int DW = irpds_pkg::DUR_W;
  localparam int SW = irpds_pkg::SHORT_W;

  // configuration
  logic [SW-1:0] leader_mark_us, leader_space_us, bit_mark_us;
  logic [SW-1:0] one_space_us, zero_space_us;
  logic [DW-1:0] frame_gap_us;
  logic          second_frame_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_us      <= irpds_pkg::LEADER_MARK_RST;
      leader_space_us     <= irpds_pkg::LEADER_SPACE_RST;
      bit_mark_us         <= irpds_pkg::BIT_MARK_RST;
      one_space_us        <= irpds_pkg::ONE_SPACE_RST;
      zero_space_us       <= irpds_pkg::ZERO_SPACE_RST;
      frame_gap_us        <= irpds_pkg::FRAME_GAP_RST;
      second_frame_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        irpds_pkg::REG_LEADER_MARK:  leader_mark_us  <= cfg_data[SW-1:0];
        irpds_pkg::REG_LEADER_SPACE: leader_space_us <= cfg_data[SW-1:0];
        irpds_pkg::REG_BIT_MARK:     bit_mark_us     <= cfg_data[SW-1:0];
        irpds_pkg::REG_ONE_SPACE:    one_space_us    <= cfg_data[SW-1:0];
        irpds_pkg::REG_ZERO_SPACE:   zero_space_us   <= cfg_data[SW-1:0];
        irpds_pkg::REG_FRAME_GAP:    frame_gap_us    <= cfg_data[DW-1:0];
        irpds_pkg::REG_SECOND_EN:    second_frame_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // transmit state
  irpds_pkg::phase_t phase, phase_next;
  logic [DW-1:0] time_left, time_left_next;
  logic [CW-1:0] byte_pos, byte_pos_next;
  logic [2:0]    bit_pos, bit_pos_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic          in_second_frame, in_second_frame_next;
  logic [CW-1:0] frame_one_count, frame_one_count_next;
  logic [CW-1:0] frame_two_count, frame_two_count_next;

  logic          accept;
  logic          busy;
  logic          load_one_we, load_two_we;
  logic          done, rej;
  logic [DW-1:0] time_dec;
  logic [CW-1:0] cur_count, byte_inc;
  logic [CW-1:0] rd_idx;
  logic [7:0]    rd_one, rd_two, cur_byte;
  irpds_pkg::result_t res;

  assign accept   = in_valid && in_ready;
  assign busy     = (phase != irpds_pkg::PH_IDLE);
  assign time_dec = time_left - DW'(1);
  assign cur_count = in_second_frame ? frame_two_count : frame_one_count;
  assign byte_inc  = byte_pos + CW'(1);
  assign cur_byte  = in_second_frame ? rd_two : rd_one;

  assign load_one_we = accept && (kind == irpds_pkg::KIND_LOAD_ONE) && !busy &&
                       (frame_one_count < CW'(MAX_BYTES));
  assign load_two_we = accept && (kind == irpds_pkg::KIND_LOAD_TWO) && !busy &&
                       (frame_two_count < CW'(MAX_BYTES));

  // Prefetch the byte that the next bit boundary needs: byte 0 before the bits,
  // the following byte while a byte is being sent.
  always_comb begin
    if (phase == irpds_pkg::PH_BIT_MARK || phase == irpds_pkg::PH_BIT_SPACE) begin
      rd_idx = byte_inc;
    end else begin
      rd_idx = '0;
    end
  end

  irpds_ram #(.WIDTH(8), .DEPTH(MAX_BYTES), .AW(AW)) u_frame_one (
    .clk   (clk),
    .we    (load_one_we),
    .waddr (frame_one_count[AW-1:0]),
    .wdata (data_byte),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_one)
  );

  irpds_ram #(.WIDTH(8), .DEPTH(MAX_BYTES), .AW(AW)) u_frame_two (
    .clk   (clk),
    .we    (load_two_we),
    .waddr (frame_two_count[AW-1:0]),
    .wdata (data_byte),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_two)
  );

  always_comb begin
    phase_next           = phase;
    time_left_next       = time_left;
    byte_pos_next        = byte_pos;
    bit_pos_next         = bit_pos;
    shift_byte_next      = shift_byte;
    in_second_frame_next = in_second_frame;
    frame_one_count_next = frame_one_count;
    frame_two_count_next = frame_two_count;
    done                 = 1'b0;
    rej                  = 1'b0;
    if (accept) begin
      case (kind)
        irpds_pkg::KIND_TICK: begin
          if (busy) begin
            time_left_next = time_dec;
            if (time_dec == '0) begin
              case (phase)
                irpds_pkg::PH_LEAD_MARK: begin
                  phase_next     = irpds_pkg::PH_LEAD_SPACE;
                  time_left_next = irpds_pkg::dur_fix(DW'(leader_space_us));
                end
                irpds_pkg::PH_LEAD_SPACE: begin
                  byte_pos_next  = '0;
                  bit_pos_next   = '0;
                  time_left_next = irpds_pkg::dur_fix(DW'(bit_mark_us));
                  if (cur_count == '0) begin
                    phase_next = irpds_pkg::PH_TRAIL_MARK;
                  end else begin
                    shift_byte_next = cur_byte;
                    phase_next      = irpds_pkg::PH_BIT_MARK;
                  end
                end
                irpds_pkg::PH_BIT_MARK: begin
                  phase_next     = irpds_pkg::PH_BIT_SPACE;
                  time_left_next = irpds_pkg::dur_fix(shift_byte[7] ?
                                   DW'(one_space_us) : DW'(zero_space_us));
                end
                irpds_pkg::PH_BIT_SPACE: begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  bit_pos_next    = bit_pos + 3'd1;
                  phase_next      = irpds_pkg::PH_BIT_MARK;
                  time_left_next  = irpds_pkg::dur_fix(DW'(bit_mark_us));
                  if (bit_pos == 3'd7) begin
                    byte_pos_next = byte_inc;
                    if (byte_inc >= cur_count) begin
                      phase_next = irpds_pkg::PH_TRAIL_MARK;
                    end else begin
                      shift_byte_next = cur_byte;
                    end
                  end
                end
                irpds_pkg::PH_TRAIL_MARK: begin
                  if (!in_second_frame && second_frame_enable) begin
                    in_second_frame_next = 1'b1;
                    phase_next           = irpds_pkg::PH_GAP;
                    time_left_next       = irpds_pkg::dur_fix(frame_gap_us);
                  end else begin
                    // drop back to idle and empty both frames
                    phase_next           = irpds_pkg::PH_IDLE;
                    time_left_next       = '0;
                    byte_pos_next        = '0;
                    bit_pos_next         = '0;
                    shift_byte_next      = '0;
                    in_second_frame_next = 1'b0;
                    frame_one_count_next = '0;
                    frame_two_count_next = '0;
                    done                 = 1'b1;
                  end
                end
                irpds_pkg::PH_GAP: begin
                  phase_next     = irpds_pkg::PH_LEAD_MARK;
                  time_left_next = irpds_pkg::dur_fix(DW'(leader_mark_us));
                end
                default: begin
                  phase_next     = irpds_pkg::PH_IDLE;
                  time_left_next = '0;
                end
              endcase
            end
          end
        end
        irpds_pkg::KIND_LOAD_ONE: begin
          if (load_one_we) begin
            frame_one_count_next = frame_one_count + CW'(1);
          end else begin
            rej = 1'b1;
          end
        end
        irpds_pkg::KIND_LOAD_TWO: begin
          if (load_two_we) begin
            frame_two_count_next = frame_two_count + CW'(1);
          end else begin
            rej = 1'b1;
          end
        end
        irpds_pkg::KIND_START: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            in_second_frame_next = 1'b0;
            byte_pos_next        = '0;
            bit_pos_next         = '0;
            shift_byte_next      = '0;
            phase_next           = irpds_pkg::PH_LEAD_MARK;
            time_left_next       = irpds_pkg::dur_fix(DW'(leader_mark_us));
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.ir_gate  = (phase_next == irpds_pkg::PH_LEAD_MARK) ||
                   (phase_next == irpds_pkg::PH_BIT_MARK) ||
                   (phase_next == irpds_pkg::PH_TRAIL_MARK);
    res.busy     = (phase_next != irpds_pkg::PH_IDLE);
    res.done     = done;
    res.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= irpds_pkg::PH_IDLE;
      time_left       <= '0;
      byte_pos        <= '0;
      bit_pos         <= '0;
      shift_byte      <= '0;
      in_second_frame <= 1'b0;
      frame_one_count <= '0;
      frame_two_count <= '0;
    end else begin
      phase           <= phase_next;
      time_left       <= time_left_next;
      byte_pos        <= byte_pos_next;
      bit_pos         <= bit_pos_next;
      shift_byte      <= shift_byte_next;
      in_second_frame <= in_second_frame_next;
      frame_one_count <= frame_one_count_next;
      frame_two_count <= frame_two_count_next;
    end
  end

  // two-entry output buffer: main register plus skid
  irpds_pkg::result_t out_res, skid_res;
  logic skid_valid;
  logic pop;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign ir_gate  = out_res.ir_gate;
  assign busy_res = out_res.busy;
  assign done_res = out_res.done;
  assign rejected = out_res.rejected;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a main entry");

  a_busy_timer: assert property (@(posedge clk) disable iff (rst)
    (phase != irpds_pkg::PH_IDLE) |-> (time_left != '0))
    else $error("active phase with an empty timer");

  a_bitpos_outside_bits: assert property (@(posedge clk) disable iff (rst)
    (phase != irpds_pkg::PH_BIT_MARK && phase != irpds_pkg::PH_BIT_SPACE)
      |-> (bit_pos == 3'd0))
    else $error("bit position left nonzero outside the bit phases");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !ir_gate && !rejected))
    else $error("done result while still busy");

  a_gate_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ir_gate) |-> busy_res)
    else $error("carrier gate on while idle");

endmodule
